// ----- rtl/hob_pkg.sv -----
`timescale 1ns / 1ps
// Shared constants, request codes and bit-search functions for the
// hierarchical occupancy bitmap. No dependencies.
package hob_pkg;

    // Band geometry: one bit per tick, 64 ticks per leaf word, 64 words per group.
    localparam int TICK_SPAN  = 16384;
    localparam int LEAF_BITS  = 64;
    localparam int BIT_W      = $clog2(LEAF_BITS);
    localparam int TICK_W     = 14;
    localparam int WORD_COUNT = (TICK_SPAN + LEAF_BITS - 1) / LEAF_BITS;
    localparam int WORD_W     = $clog2(WORD_COUNT);
    localparam int MID_COUNT  = (WORD_COUNT + LEAF_BITS - 1) / LEAF_BITS;
    localparam int MID_W      = $clog2(MID_COUNT);
    localparam int KIND_W     = 2;

    // Request codes.
    localparam logic [KIND_W-1:0] KIND_SET   = 2'd0;
    localparam logic [KIND_W-1:0] KIND_CLEAR = 2'd1;
    localparam logic [KIND_W-1:0] KIND_BELOW = 2'd2;
    localparam logic [KIND_W-1:0] KIND_ABOVE = 2'd3;

    typedef logic [LEAF_BITS-1:0] leaf_word_t;

    // Index of the highest set bit, found by halving; zero for an empty word.
    function automatic logic [BIT_W-1:0] top_bit(input leaf_word_t x);
        leaf_word_t       v;
        logic [BIT_W-1:0] n;
        v = x;
        n = '0;
        if (v[63:32] != '0)
        begin
            n[5] = 1'b1;
            v    = v >> 32;
        end
        if (v[31:16] != '0)
        begin
            n[4] = 1'b1;
            v    = v >> 16;
        end
        if (v[15:8] != '0)
        begin
            n[3] = 1'b1;
            v    = v >> 8;
        end
        if (v[7:4] != '0)
        begin
            n[2] = 1'b1;
            v    = v >> 4;
        end
        if (v[3:2] != '0)
        begin
            n[1] = 1'b1;
            v    = v >> 2;
        end
        if (v[1] != 1'b0)
        begin
            n[0] = 1'b1;
        end
        return n;
    endfunction

    // Index of the lowest set bit: the highest set bit of the reversed word.
    function automatic logic [BIT_W-1:0] bottom_bit(input leaf_word_t x);
        leaf_word_t r;
        for (int i = 0; i < LEAF_BITS; i++)
        begin
            r[i] = x[LEAF_BITS-1-i];
        end
        return ~top_bit(r);
    endfunction

    // Searching above takes the lowest candidate, searching below the highest.
    function automatic logic [BIT_W-1:0] pick_bit(input leaf_word_t x, input logic up);
        return up ? bottom_bit(x) : top_bit(x);
    endfunction

    // Bits strictly under position b.
    function automatic leaf_word_t bits_under(input logic [BIT_W-1:0] b);
        leaf_word_t ones;
        ones = '1;
        return ~(ones << b);
    endfunction

    // Bits strictly over position b; empty for the top position.
    function automatic leaf_word_t bits_over(input logic [BIT_W-1:0] b);
        leaf_word_t ones;
        ones = '1;
        return (ones << b) << 1;
    endfunction

endpackage

// ----- rtl/hierarchical_occupancy_bitmap.sv -----
`timescale 1ns / 1ps
// Top level of the hierarchical occupancy bitmap: leaf word memory, group
// summary memory, top summary register and the request sequencer. Uses hob_pkg.

// The block holds a three-level occupancy map over 16384 ticks and takes one
// request at a time: set a tick, clear a tick, or find the nearest occupied
// tick strictly below or above a given one. Each request gives one result beat
// carrying the search outcome and the occupancy of the whole band afterwards.
// A request passes through the update, mid, leaf and output states, and the
// next request is taken only once its result is in the output register. The
// steps follow the chain of dependent reads from the two memories with registered
// read data: leaf word and group summary, then the summary of a further group,
// then the second leaf word of a search with the summaries of the extreme groups,
// then the leaf words holding the highest and lowest ticks. Both memories come
// out of reset empty at once (per-entry valid bits), with no clearing pass. While
// a result beat is stalled the sequencer waits with the next result ready.
module hierarchical_occupancy_bitmap
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    output logic                              in_stall,
    input  logic [hob_pkg::KIND_W-1:0]        kind,
    input  logic [hob_pkg::TICK_W-1:0]        tick,
    output logic                              out_valid,
    input  logic                              out_stall,
    output logic                              hit,
    output logic [hob_pkg::TICK_W-1:0]        hit_tick,
    output logic                              any_occupied,
    output logic [hob_pkg::TICK_W-1:0]        highest_tick,
    output logic [hob_pkg::TICK_W-1:0]        lowest_tick
);

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_UPD  = 3'd1;
    localparam logic [2:0] ST_MID  = 3'd2;
    localparam logic [2:0] ST_LEAF = 3'd3;
    localparam logic [2:0] ST_OUT  = 3'd4;

    localparam logic [1:0] PATH_DONE  = 2'd0;
    localparam logic [1:0] PATH_WORD  = 2'd1;
    localparam logic [1:0] PATH_GROUP = 2'd2;

    localparam int PAD_W = hob_pkg::LEAF_BITS - hob_pkg::MID_COUNT;

    // Sequencer and request registers.
    logic [2:0]                       state_reg, state_next;
    logic [1:0]                       path_reg, path_next;
    logic [hob_pkg::KIND_W-1:0]       kind_reg;
    logic [hob_pkg::TICK_W-1:0]       tick_reg;
    logic                             found_hit_reg, found_hit_next;
    logic [hob_pkg::TICK_W-1:0]       found_reg, found_next;
    logic [hob_pkg::WORD_W-1:0]       w2_reg, w2_next;
    logic [hob_pkg::MID_W-1:0]        m2_reg, m2_next;
    logic [hob_pkg::MID_W-1:0]        mh_reg, mh_next;
    logic [hob_pkg::MID_W-1:0]        ml_reg, ml_next;
    logic [hob_pkg::WORD_W-1:0]       wh_reg, wh_next;
    logic [hob_pkg::WORD_W-1:0]       wl_reg, wl_next;
    logic [hob_pkg::MID_COUNT-1:0]    top_reg, top_next;

    // Output register.
    logic                             out_valid_reg, out_valid_next;
    logic                             hit_reg, hit_next;
    logic [hob_pkg::TICK_W-1:0]       hit_tick_reg, hit_tick_next;
    logic                             any_reg, any_next;
    logic [hob_pkg::TICK_W-1:0]       high_reg, high_next;
    logic [hob_pkg::TICK_W-1:0]       low_reg, low_next;

    // Leaf word memory with two read ports and one write port.
    hob_pkg::leaf_word_t              leaf_mem [hob_pkg::WORD_COUNT];
    logic [hob_pkg::WORD_COUNT-1:0]   leaf_vld_reg;
    hob_pkg::leaf_word_t              leaf_qa_reg, leaf_qb_reg;
    logic                             leaf_va_reg, leaf_vb_reg;
    logic                             leaf_we, leaf_rea, leaf_reb;
    logic [hob_pkg::WORD_W-1:0]       leaf_wa, leaf_ra_a, leaf_ra_b;
    hob_pkg::leaf_word_t              leaf_wd;

    // Group summary memory with two read ports and one write port.
    hob_pkg::leaf_word_t              mid_mem [hob_pkg::MID_COUNT];
    logic [hob_pkg::MID_COUNT-1:0]    mid_vld_reg;
    hob_pkg::leaf_word_t              mid_qa_reg, mid_qb_reg;
    logic                             mid_va_reg, mid_vb_reg;
    logic                             mid_we, mid_rea, mid_reb;
    logic [hob_pkg::MID_W-1:0]        mid_wa, mid_ra_a, mid_ra_b;
    hob_pkg::leaf_word_t              mid_wd;

    // Decoded views of the current request and read data.
    hob_pkg::leaf_word_t              leaf_a, leaf_b, mid_a, mid_b;
    hob_pkg::leaf_word_t              bit_sel, word_sel;
    hob_pkg::leaf_word_t              rest_l, rest_m;
    logic [hob_pkg::MID_COUNT-1:0]    grp_sel, grp_ones, rest_t;
    logic [hob_pkg::BIT_W-1:0]        grp_hi6, grp_lo6, rest_t6;
    logic [hob_pkg::MID_W-1:0]        req_grp;
    logic [hob_pkg::BIT_W-1:0]        req_word_bit, req_bit;
    logic                             up;
    logic                             accept;

    assign accept = in_valid && !in_stall;
    assign in_stall = (state_reg != ST_IDLE);

    assign leaf_a = leaf_va_reg ? leaf_qa_reg : '0;
    assign leaf_b = leaf_vb_reg ? leaf_qb_reg : '0;
    assign mid_a  = mid_va_reg  ? mid_qa_reg  : '0;
    assign mid_b  = mid_vb_reg  ? mid_qb_reg  : '0;

    // Split the tick into group, word-in-group and bit-in-word.
    assign req_grp      = tick_reg[hob_pkg::TICK_W-1 -: hob_pkg::MID_W];
    assign req_word_bit = tick_reg[2*hob_pkg::BIT_W-1 -: hob_pkg::BIT_W];
    assign req_bit      = tick_reg[hob_pkg::BIT_W-1:0];
    assign up           = (kind_reg == hob_pkg::KIND_ABOVE);

    assign bit_sel  = hob_pkg::leaf_word_t'(1) << req_bit;
    assign word_sel = hob_pkg::leaf_word_t'(1) << req_word_bit;
    assign grp_sel  = {{(hob_pkg::MID_COUNT-1){1'b0}}, 1'b1} << req_grp;
    assign grp_ones = '1;

    // Candidates in the searched direction at each level.
    assign rest_l = leaf_a & (up ? hob_pkg::bits_over(req_bit) : hob_pkg::bits_under(req_bit));
    assign rest_m = mid_a & (up ? hob_pkg::bits_over(req_word_bit)
                                : hob_pkg::bits_under(req_word_bit));
    assign rest_t = top_reg & (up ? ((grp_ones << req_grp) << 1) : ~(grp_ones << req_grp));

    assign rest_t6 = hob_pkg::pick_bit({{PAD_W{1'b0}}, rest_t}, up);
    assign grp_hi6 = hob_pkg::top_bit({{PAD_W{1'b0}}, top_reg});
    assign grp_lo6 = hob_pkg::bottom_bit({{PAD_W{1'b0}}, top_reg});

    // Sequencer: update, then follow the summaries down to the answering words.
    always_comb
    begin
        state_next     = state_reg;
        path_next      = path_reg;
        found_hit_next = found_hit_reg;
        found_next     = found_reg;
        w2_next        = w2_reg;
        m2_next        = m2_reg;
        mh_next        = mh_reg;
        ml_next        = ml_reg;
        wh_next        = wh_reg;
        wl_next        = wl_reg;
        top_next       = top_reg;
        out_valid_next = out_valid_reg;
        hit_next       = hit_reg;
        hit_tick_next  = hit_tick_reg;
        any_next       = any_reg;
        high_next      = high_reg;
        low_next       = low_reg;
        leaf_we        = 1'b0;
        leaf_wa        = tick_reg[hob_pkg::TICK_W-1 -: hob_pkg::WORD_W];
        leaf_wd        = '0;
        leaf_rea       = 1'b0;
        leaf_ra_a      = tick[hob_pkg::TICK_W-1 -: hob_pkg::WORD_W];
        leaf_reb       = 1'b0;
        leaf_ra_b      = wl_reg;
        mid_we         = 1'b0;
        mid_wa         = req_grp;
        mid_wd         = '0;
        mid_rea        = 1'b0;
        mid_ra_a       = tick[hob_pkg::TICK_W-1 -: hob_pkg::MID_W];
        mid_reb        = 1'b0;
        mid_ra_b       = ml_reg;

        // A result beat leaves when the far side takes it.
        if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    leaf_rea   = 1'b1;
                    mid_rea    = 1'b1;
                    state_next = ST_UPD;
                end
            end

            ST_UPD:
            begin
                found_hit_next = 1'b0;
                found_next     = '0;
                path_next      = PATH_DONE;
                case (kind_reg)
                    hob_pkg::KIND_SET:
                    begin
                        leaf_we  = 1'b1;
                        leaf_wd  = leaf_a | bit_sel;
                        mid_we   = 1'b1;
                        mid_wd   = mid_a | word_sel;
                        top_next = top_reg | grp_sel;
                    end
                    hob_pkg::KIND_CLEAR:
                    begin
                        leaf_we = 1'b1;
                        leaf_wd = leaf_a & ~bit_sel;
                        // Summaries change only when the leaf word empties.
                        if (leaf_wd == '0)
                        begin
                            mid_we = 1'b1;
                            mid_wd = mid_a & ~word_sel;
                            if (mid_wd == '0)
                            begin
                                top_next = top_reg & ~grp_sel;
                            end
                        end
                    end
                    default:
                    begin
                        // Search: own word first, then own group, then other groups.
                        if (rest_l != '0)
                        begin
                            found_hit_next = 1'b1;
                            found_next     = {tick_reg[hob_pkg::TICK_W-1 -: hob_pkg::WORD_W],
                                              hob_pkg::pick_bit(rest_l, up)};
                        end
                        else if (rest_m != '0)
                        begin
                            path_next = PATH_WORD;
                            w2_next   = {req_grp, hob_pkg::pick_bit(rest_m, up)};
                        end
                        else if (rest_t != '0)
                        begin
                            path_next = PATH_GROUP;
                            m2_next   = rest_t6[hob_pkg::MID_W-1:0];
                            mid_rea   = 1'b1;
                            mid_ra_a  = rest_t6[hob_pkg::MID_W-1:0];
                        end
                    end
                endcase
                state_next = ST_MID;
            end

            ST_MID:
            begin
                // Summaries of the groups holding the highest and lowest ticks.
                mh_next  = grp_hi6[hob_pkg::MID_W-1:0];
                ml_next  = grp_lo6[hob_pkg::MID_W-1:0];
                mid_rea  = 1'b1;
                mid_ra_a = grp_hi6[hob_pkg::MID_W-1:0];
                mid_reb  = 1'b1;
                mid_ra_b = grp_lo6[hob_pkg::MID_W-1:0];
                // The search word, from another group when the summary was fetched.
                if (path_reg == PATH_GROUP)
                begin
                    w2_next = {m2_reg, hob_pkg::pick_bit(mid_a, up)};
                end
                if (path_reg != PATH_DONE)
                begin
                    leaf_rea  = 1'b1;
                    leaf_ra_a = w2_next;
                end
                state_next = ST_LEAF;
            end

            ST_LEAF:
            begin
                if (path_reg != PATH_DONE)
                begin
                    found_hit_next = 1'b1;
                    found_next     = {w2_reg, hob_pkg::pick_bit(leaf_a, up)};
                end
                wh_next    = {mh_reg, hob_pkg::top_bit(mid_a)};
                wl_next    = {ml_reg, hob_pkg::bottom_bit(mid_b)};
                leaf_rea   = 1'b1;
                leaf_ra_a  = wh_next;
                leaf_reb   = 1'b1;
                leaf_ra_b  = wl_next;
                state_next = ST_OUT;
            end

            ST_OUT:
            begin
                // Load the result beat once the output register is free.
                if (!out_valid_reg || !out_stall)
                begin
                    out_valid_next = 1'b1;
                    hit_next       = found_hit_reg;
                    hit_tick_next  = found_reg;
                    any_next       = (top_reg != '0);
                    if (top_reg != '0)
                    begin
                        high_next = {wh_reg, hob_pkg::top_bit(leaf_a)};
                        low_next  = {wl_reg, hob_pkg::bottom_bit(leaf_b)};
                    end
                    else
                    begin
                        high_next = '0;
                        low_next  = '0;
                    end
                    state_next = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            top_reg       <= '0;
            out_valid_reg <= 1'b0;
            leaf_vld_reg  <= '0;
            mid_vld_reg   <= '0;
            leaf_va_reg   <= 1'b0;
            leaf_vb_reg   <= 1'b0;
            mid_va_reg    <= 1'b0;
            mid_vb_reg    <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            top_reg       <= top_next;
            out_valid_reg <= out_valid_next;
            if (leaf_we)
            begin
                leaf_vld_reg[leaf_wa] <= 1'b1;
            end
            if (mid_we)
            begin
                mid_vld_reg[mid_wa] <= 1'b1;
            end
            if (leaf_rea)
            begin
                leaf_va_reg <= leaf_vld_reg[leaf_ra_a];
            end
            if (leaf_reb)
            begin
                leaf_vb_reg <= leaf_vld_reg[leaf_ra_b];
            end
            if (mid_rea)
            begin
                mid_va_reg <= mid_vld_reg[mid_ra_a];
            end
            if (mid_reb)
            begin
                mid_vb_reg <= mid_vld_reg[mid_ra_b];
            end
        end
    end

    // Request and working payload.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            kind_reg <= kind;
            tick_reg <= tick;
        end
        path_reg      <= path_next;
        found_hit_reg <= found_hit_next;
        found_reg     <= found_next;
        w2_reg        <= w2_next;
        m2_reg        <= m2_next;
        mh_reg        <= mh_next;
        ml_reg        <= ml_next;
        wh_reg        <= wh_next;
        wl_reg        <= wl_next;
        hit_reg       <= hit_next;
        hit_tick_reg  <= hit_tick_next;
        any_reg       <= any_next;
        high_reg      <= high_next;
        low_reg       <= low_next;
    end

    // Leaf word memory.
    always_ff @(posedge clk)
    begin
        if (leaf_we)
        begin
            leaf_mem[leaf_wa] <= leaf_wd;
        end
        if (leaf_rea)
        begin
            leaf_qa_reg <= leaf_mem[leaf_ra_a];
        end
        if (leaf_reb)
        begin
            leaf_qb_reg <= leaf_mem[leaf_ra_b];
        end
    end

    // Group summary memory.
    always_ff @(posedge clk)
    begin
        if (mid_we)
        begin
            mid_mem[mid_wa] <= mid_wd;
        end
        if (mid_rea)
        begin
            mid_qa_reg <= mid_mem[mid_ra_a];
        end
        if (mid_reb)
        begin
            mid_qb_reg <= mid_mem[mid_ra_b];
        end
    end

    assign out_valid    = out_valid_reg;
    assign hit          = hit_reg;
    assign hit_tick     = hit_tick_reg;
    assign any_occupied = any_reg;
    assign highest_tick = high_reg;
    assign lowest_tick  = low_reg;

endmodule

// ----- verif/tb.sv -----
`timescale 1ns / 1ps
// Self-checking testbench for hierarchical_occupancy_bitmap: directed and random
// set, clear and search requests checked against a leaf-word occupancy predictor.
// Depends on hob_pkg and the hierarchical_occupancy_bitmap top level.
module tb;

    typedef logic [hob_pkg::KIND_W-1:0] kind_t;
    typedef logic [hob_pkg::TICK_W-1:0] tick_t;
    typedef logic [hob_pkg::BIT_W-1:0]  bit_pos_t;

    // One request beat waiting to be driven, with the idle cycles placed before it.
    typedef struct {
        kind_t kind;
        tick_t tick;
        int    gap;
    } request_t;

    // One result beat as the block should present it.
    typedef struct packed {
        logic  hit;
        tick_t hit_tick;
        logic  any_occupied;
        tick_t highest_tick;
        tick_t lowest_tick;
    } outcome_t;

    logic              clk;
    logic              rst_n;
    logic              in_valid;
    logic              in_stall;
    kind_t             kind;
    tick_t             tick;
    logic              out_valid;
    logic              out_stall;
    logic              hit;
    tick_t             hit_tick;
    logic              any_occupied;
    tick_t             highest_tick;
    tick_t             lowest_tick;

    request_t            request_queue[$];
    outcome_t            expected_outcomes[$];
    hob_pkg::leaf_word_t occupancy_words [hob_pkg::WORD_COUNT];
    logic [7:0]          hot_words [8];
    bit                  quiet_sender;
    int                  send_wait;
    int                  stall_wait;
    int                  quiet_beats;
    int                  beats_seen;
    logic                long_hold;
    int                  mismatches;

    hierarchical_occupancy_bitmap uut
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .kind         (kind),
        .tick         (tick),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .hit          (hit),
        .hit_tick     (hit_tick),
        .any_occupied (any_occupied),
        .highest_tick (highest_tick),
        .lowest_tick  (lowest_tick)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Highest and lowest set bit of a leaf word; zero for an empty word.
    function automatic int msb_index(input hob_pkg::leaf_word_t x);
        int pos;
        pos = 0;
        for (int i = 0; i < hob_pkg::LEAF_BITS; i++)
        begin
            if (x[i])
                pos = i;
        end
        return pos;
    endfunction

    function automatic int lsb_index(input hob_pkg::leaf_word_t x);
        int pos;
        pos = 0;
        for (int i = hob_pkg::LEAF_BITS - 1; i >= 0; i--)
        begin
            if (x[i])
                pos = i;
        end
        return pos;
    endfunction

    // Applies one request to the occupancy copy and returns the result it should give.
    // The summary levels only speed up the block's search, so a scan of the leaf
    // words gives the same answers.
    function automatic outcome_t apply_request(input kind_t k, input tick_t t);
        outcome_t            res;
        int                  w;
        int                  b;
        hob_pkg::leaf_word_t part;
        hob_pkg::leaf_word_t ones;
        res  = '0;
        w    = t >> hob_pkg::BIT_W;
        b    = t[hob_pkg::BIT_W-1:0];
        ones = '1;
        case (k)
            hob_pkg::KIND_SET:
                occupancy_words[w][b] = 1'b1;
            hob_pkg::KIND_CLEAR:
                occupancy_words[w][b] = 1'b0;
            hob_pkg::KIND_BELOW:
            begin
                part = occupancy_words[w] & ~(ones << b);
                if (part != '0)
                begin
                    res.hit      = 1'b1;
                    res.hit_tick = tick_t'(w * hob_pkg::LEAF_BITS + msb_index(part));
                end
                for (int i = w - 1; i >= 0; i--)
                begin
                    if (!res.hit && occupancy_words[i] != '0)
                    begin
                        res.hit      = 1'b1;
                        res.hit_tick = tick_t'(i * hob_pkg::LEAF_BITS
                                               + msb_index(occupancy_words[i]));
                    end
                end
            end
            default:
            begin
                part = occupancy_words[w] & ((ones << b) << 1);
                if (part != '0)
                begin
                    res.hit      = 1'b1;
                    res.hit_tick = tick_t'(w * hob_pkg::LEAF_BITS + lsb_index(part));
                end
                for (int i = w + 1; i < hob_pkg::WORD_COUNT; i++)
                begin
                    if (!res.hit && occupancy_words[i] != '0)
                    begin
                        res.hit      = 1'b1;
                        res.hit_tick = tick_t'(i * hob_pkg::LEAF_BITS
                                               + lsb_index(occupancy_words[i]));
                    end
                end
            end
        endcase

        // Band extremes after the step.
        for (int i = 0; i < hob_pkg::WORD_COUNT; i++)
        begin
            if (occupancy_words[i] != '0)
            begin
                if (!res.any_occupied)
                    res.lowest_tick = tick_t'(i * hob_pkg::LEAF_BITS
                                              + lsb_index(occupancy_words[i]));
                res.any_occupied = 1'b1;
                res.highest_tick = tick_t'(i * hob_pkg::LEAF_BITS
                                           + msb_index(occupancy_words[i]));
            end
        end
        return res;
    endfunction

    task automatic add_request(input kind_t k, input tick_t t);
        request_t req;
        req.kind = k;
        req.tick = t;
        req.gap  = quiet_sender ? 0 : $urandom_range(0, 3);
        request_queue.insert(request_queue.size(), req);
    endtask

    // Ticks crowd into a few hot words at a handful of bit positions, so that
    // sets, clears and searches keep meeting each other and words empty out.
    function automatic tick_t pick_tick(input bit anywhere);
        tick_t t;
        if (anywhere)
            t = tick_t'($urandom_range(0, hob_pkg::TICK_SPAN - 1));
        else
            t = {hot_words[$urandom_range(0, 7)], bit_pos_t'($urandom_range(0, 7) * 9)};
        return t;
    endfunction

    // Driver: presents queued requests, idling before each as its gap says.
    always @(posedge clk or negedge rst_n)
    begin : sender
        request_t next_req;
        if (!rst_n)
        begin
            in_valid  <= 1'b0;
            kind      <= hob_pkg::KIND_SET;
            tick      <= '0;
            send_wait <= 0;
        end
        else if (!in_valid || !in_stall)
        begin
            // A beat was taken at this edge: predict its result now.
            if (in_valid)
                expected_outcomes.insert(expected_outcomes.size(),
                                         apply_request(kind, tick));
            if (request_queue.size() == 0)
            begin
                in_valid <= 1'b0;
            end
            else if (send_wait < request_queue[0].gap)
            begin
                in_valid  <= 1'b0;
                send_wait <= send_wait + 1;
            end
            else
            begin
                next_req  = request_queue.pop_front();
                kind      <= next_req.kind;
                tick      <= next_req.tick;
                in_valid  <= 1'b1;
                send_wait <= 0;
            end
        end
    end

    // Monitor: checks each result beat and stalls at random after it.
    always @(posedge clk or negedge rst_n)
    begin : receiver
        int       wait_n;
        int       quiet_n;
        outcome_t want;
        if (!rst_n)
        begin
            out_stall   <= 1'b0;
            stall_wait  <= 0;
            quiet_beats <= 0;
            beats_seen  <= 0;
        end
        else
        begin
            wait_n  = stall_wait;
            quiet_n = quiet_beats;
            if (out_valid && !out_stall)
            begin
                if (expected_outcomes.size() == 0)
                begin
                    if (mismatches < 10)
                        $display("%0t: result beat with nothing expected", $time);
                    mismatches++;
                end
                else
                begin
                    want = expected_outcomes.pop_front();
                    if (hit !== want.hit || hit_tick !== want.hit_tick
                        || any_occupied !== want.any_occupied
                        || highest_tick !== want.highest_tick
                        || lowest_tick !== want.lowest_tick)
                    begin
                        if (mismatches < 10)
                            $display({"%0t: expected hit %0d at %0d any %0d high %0d low %0d,",
                                      " got hit %0d at %0d any %0d high %0d low %0d"},
                                     $time, want.hit, want.hit_tick, want.any_occupied,
                                     want.highest_tick, want.lowest_tick, hit, hit_tick,
                                     any_occupied, highest_tick, lowest_tick);
                        mismatches++;
                    end
                end
                beats_seen <= beats_seen + 1;
                // Now and then a run of beats is taken with no stall at all.
                if (quiet_n != 0)
                    quiet_n--;
                else if ($urandom_range(0, 7) == 0)
                    quiet_n = 20;
                wait_n = (quiet_n != 0) ? 0 : $urandom_range(0, 3);
            end
            else if (wait_n != 0)
            begin
                wait_n--;
            end
            stall_wait  <= wait_n;
            quiet_beats <= quiet_n;
            out_stall   <= long_hold || (wait_n != 0);
        end
    end

    // One long hold-off on the result side, so the block backs up onto its input.
    initial
    begin : hold_off
        long_hold = 1'b0;
        while (beats_seen < 400)
            @(posedge clk);
        long_hold <= 1'b1;
        repeat (300) @(posedge clk);
        long_hold <= 1'b0;
    end

    initial
    begin
        #2000000;
        $display("end of test: mismatches");
        $finish;
    end

    initial
    begin : stimulus
        int    set_pct;
        int    clear_pct;
        int    spread;
        int    roll;
        bit    anywhere;
        tick_t t;
        kind_t dir;
        mismatches   = 0;
        quiet_sender = 1'b0;
        rst_n        = 1'b0;
        for (int i = 0; i < hob_pkg::WORD_COUNT; i++)
            occupancy_words[i] = '0;
        // Word and group boundaries are hot from the start.
        hot_words = '{8'd0, 8'd1, 8'd63, 8'd64, 8'd128, 8'd191, 8'd192, 8'd255};

        // Directed: empty band, band edges, group boundaries, repeated set,
        // clear of a free tick, and clears that empty a word and a group.
        add_request(hob_pkg::KIND_BELOW, 14'd0);
        add_request(hob_pkg::KIND_ABOVE, 14'd16383);
        add_request(hob_pkg::KIND_ABOVE, 14'd0);
        add_request(hob_pkg::KIND_BELOW, 14'd16383);
        add_request(hob_pkg::KIND_SET,   14'd0);
        add_request(hob_pkg::KIND_SET,   14'd16383);
        add_request(hob_pkg::KIND_SET,   14'd16383);
        add_request(hob_pkg::KIND_BELOW, 14'd0);
        add_request(hob_pkg::KIND_ABOVE, 14'd16383);
        add_request(hob_pkg::KIND_BELOW, 14'd16383);
        add_request(hob_pkg::KIND_ABOVE, 14'd0);
        add_request(hob_pkg::KIND_SET,   14'd4095);
        add_request(hob_pkg::KIND_SET,   14'd4096);
        add_request(hob_pkg::KIND_ABOVE, 14'd4095);
        add_request(hob_pkg::KIND_BELOW, 14'd4096);
        add_request(hob_pkg::KIND_CLEAR, 14'd5);
        add_request(hob_pkg::KIND_CLEAR, 14'd0);
        add_request(hob_pkg::KIND_BELOW, 14'd4095);
        add_request(hob_pkg::KIND_CLEAR, 14'd4095);
        add_request(hob_pkg::KIND_BELOW, 14'd4096);
        add_request(hob_pkg::KIND_CLEAR, 14'd100);
        add_request(hob_pkg::KIND_CLEAR, 14'd4096);
        add_request(hob_pkg::KIND_CLEAR, 14'd16383);
        add_request(hob_pkg::KIND_BELOW, 14'd16383);
        add_request(hob_pkg::KIND_ABOVE, 14'd0);

        // Random phases, each with its own balance of sets, clears and searches.
        for (int p = 0; p < 9; p++)
        begin
            set_pct   = $urandom_range(15, 60);
            clear_pct = $urandom_range(10, 50);
            spread    = (p % 2 == 0) ? 10 : 0;
            hot_words[$urandom_range(0, 7)] = 8'($urandom_range(0, hob_pkg::WORD_COUNT - 1));
            for (int n = 0; n < 200; n++)
            begin
                if (n % 50 == 0)
                    quiet_sender = ($urandom_range(0, 3) == 0);
                roll     = $urandom_range(0, 99);
                anywhere = ($urandom_range(0, 99) < spread);
                if (roll < set_pct)
                begin
                    add_request(hob_pkg::KIND_SET, pick_tick(anywhere));
                end
                else if (roll < set_pct + clear_pct)
                begin
                    add_request(hob_pkg::KIND_CLEAR, pick_tick(anywhere));
                end
                else
                begin
                    dir = $urandom_range(0, 1) ? hob_pkg::KIND_ABOVE : hob_pkg::KIND_BELOW;
                    case ($urandom_range(0, 9))
                        0:       t = '0;
                        1:       t = '1;
                        2, 3:    t = pick_tick(1'b1);
                        default: t = {hot_words[$urandom_range(0, 7)],
                                      bit_pos_t'($urandom_range(0, hob_pkg::LEAF_BITS - 1))};
                    endcase
                    add_request(dir, t);
                end
            end
        end

        // Reset held, then released at a clock edge.
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;

        // Drain: everything sent and every result back, then a quiet tail.
        @(posedge clk);
        while (request_queue.size() != 0 || in_valid || expected_outcomes.size() != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);

        if (expected_outcomes.size() != 0)
            mismatches = mismatches + expected_outcomes.size();
        if (mismatches == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule
